>>> src/pcid_pkg.sv
// shared types and constants of the pin change interrupt dispatcher
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package pcid_pkg;

  // fixed field widths
  localparam int MAX_PINS    = 16;
  localparam int IDX_W       = 4;
  localparam int VALUE_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 64;

  // parameter defaults
  localparam int PIN_COUNT_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  // trigger mode codes, two bits per pin
  localparam logic [1:0] TRIG_ANY     = 2'd0;
  localparam logic [1:0] TRIG_RISE    = 2'd1;
  localparam logic [1:0] TRIG_FALL    = 2'd2;
  localparam logic [1:0] TRIG_ANY_ALT = 2'd3;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IRQ_ENABLE = 1'b0,
    CFG_TRIG_MODE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    action_e              action;
    logic [MAX_PINS-1:0]  pin_levels;
    logic [IDX_W-1:0]     counter_index;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   counter_value;
    logic [MAX_PINS-1:0]  changed_mask;
    logic [MAX_PINS-1:0]  fire_mask;
  } result_t;

endpackage

>>> src/pcid_in_stage.sv
// input register of the dispatcher: holds one accepted item
// depends on pcid_pkg
`timescale 1ns / 1ps

module pcid_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  pcid_pkg::item_t item_i,
  input  logic            down_ready_i,
  output logic            valid_o,
  output pcid_pkg::item_t item_o
);

  logic            valid_q;
  pcid_pkg::item_t item_q;

  // takes a new item when empty or whenever the held one leaves in the same cycle
  assign s_ready_o = !valid_q || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> src/pcid_core.sv
// per-pin change detection, edge qualification and change counters
// depends on pcid_pkg
`timescale 1ns / 1ps

module pcid_core #(
  parameter int PIN_COUNT  = pcid_pkg::PIN_COUNT_DEF,
  parameter int COUNT_BITS = pcid_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pcid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcid_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                advance_i,
  input  pcid_pkg::item_t                     item_i,
  output pcid_pkg::result_t                   result_o
);

  localparam logic [pcid_pkg::MAX_PINS-1:0] PinMask =
    pcid_pkg::MAX_PINS'((32'd1 << PIN_COUNT) - 32'd1);

  logic [pcid_pkg::MAX_PINS-1:0]   en_q;
  logic [2*pcid_pkg::MAX_PINS-1:0] trig_q;
  logic [pcid_pkg::MAX_PINS-1:0]   last_q;
  logic                            primed_q;
  logic [COUNT_BITS-1:0]           cnt_q [PIN_COUNT];

  logic [pcid_pkg::MAX_PINS-1:0]   levels;
  logic [pcid_pkg::MAX_PINS-1:0]   changed;
  logic [pcid_pkg::MAX_PINS-1:0]   fire;
  logic [pcid_pkg::VALUE_W-1:0]    value;
  logic                            is_sample;

  assign levels    = item_i.pin_levels & PinMask;
  assign is_sample = (item_i.action == pcid_pkg::ACT_SAMPLE);

  always_comb begin
    logic [1:0] mode;
    logic       hit;
    changed = '0;
    fire    = '0;
    value   = '0;
    mode    = pcid_pkg::TRIG_ANY;
    hit     = 1'b0;
    if (!is_sample) begin
      // counter select; an index past the last pin reads zero
      for (int i = 0; i < PIN_COUNT; i++) begin
        if (item_i.counter_index == pcid_pkg::IDX_W'(i)) begin
          value = pcid_pkg::VALUE_W'(cnt_q[i]);
        end
      end
    end else if (primed_q) begin
      changed = (last_q ^ levels) & PinMask;
      for (int i = 0; i < PIN_COUNT; i++) begin
        mode = trig_q[2*i +: 2];
        hit  = changed[i] & en_q[i];
        case (mode)
          pcid_pkg::TRIG_RISE: hit = hit & levels[i];
          pcid_pkg::TRIG_FALL: hit = hit & ~levels[i];
          default:             hit = hit;
        endcase
        fire[i] = hit;
      end
    end
  end

  assign result_o.fire_mask     = fire;
  assign result_o.changed_mask  = changed;
  assign result_o.counter_value = value;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      trig_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pcid_pkg::cfg_reg_e'(cfg_index_i))
        pcid_pkg::CFG_IRQ_ENABLE: en_q   <= cfg_wdata_i[pcid_pkg::MAX_PINS-1:0];
        pcid_pkg::CFG_TRIG_MODE:  trig_q <= cfg_wdata_i[2*pcid_pkg::MAX_PINS-1:0];
        default:                  en_q   <= en_q;
      endcase
    end
  end

  // previous sample; the first sample after reset only primes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      primed_q <= 1'b0;
    end else if (advance_i && is_sample) begin
      last_q   <= levels;
      primed_q <= 1'b1;
    end
  end

  // wrapping change counters, one per pin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIN_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (advance_i) begin
      for (int i = 0; i < PIN_COUNT; i++) begin
        if (changed[i]) begin
          cnt_q[i] <= cnt_q[i] + COUNT_BITS'(1);
        end
      end
    end
  end

endmodule

>>> src/pcid_out_stage.sv
// result register of the dispatcher, toward the master side
// depends on pcid_pkg
`timescale 1ns / 1ps

module pcid_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pcid_pkg::result_t result_i,
  output logic              ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output pcid_pkg::result_t result_o
);

  logic              valid_q;
  pcid_pkg::result_t result_q;

  assign ready_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign result_o  = result_q;

endmodule

>>> src/pin_change_irq_dispatch_top.sv
// Pin change interrupt dispatcher. Each item is either a 16-pin level sample or a request
// to read one pin's change counter. A sample is compared with the previous one; changed
// pins are counted (wrapping) and reported, and those that are enabled and whose edge
// matches their trigger mode (any, rising or falling) are flagged in fire_mask. The
// first sample after reset only primes the previous levels and reports zero masks.
// A read returns the counter of the selected pin and zero masks. One item is taken
// every cycle while the master side keeps taking results; an item is held in the input
// register, and its result is computed as it moves into the result register, from
// which it is presented. A stalled master side fills the result register and then the
// input register, after which s_axis_tready stays low until a result leaves.
// Configuration writes must only be issued while no item is in flight.
// depends on pcid_pkg, pcid_in_stage, pcid_core, pcid_out_stage
`timescale 1ns / 1ps

module pin_change_irq_dispatch_top #(
  parameter int PIN_COUNT  = pcid_pkg::PIN_COUNT_DEF,
  parameter int COUNT_BITS = pcid_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: 0 irq_enable_mask, 1 trig_mode
  input  logic                                cfg_we_i,
  input  logic [pcid_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcid_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // slave side
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // pin_levels [15:0], counter_index [19:16], zero fill [23:20]
  input  logic [pcid_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // action [0]
  input  logic [pcid_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,
  // master side
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // fire_mask [15:0], changed_mask [31:16], counter_value [63:32]
  output logic [pcid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  pcid_pkg::item_t   in_item;
  pcid_pkg::item_t   held_item;
  pcid_pkg::result_t core_result;
  pcid_pkg::result_t out_result;
  logic              held_valid;
  logic              out_ready;
  logic              advance;

  // unpack the slave item
  assign in_item.action        = pcid_pkg::action_e'(s_axis_tuser_i[0]);
  assign in_item.pin_levels    = s_axis_tdata_i[15:0];
  assign in_item.counter_index = s_axis_tdata_i[19:16];

  // the held item is processed in the cycle it moves into the result register
  assign advance = held_valid && out_ready;

  pcid_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .item_i       (in_item),
    .down_ready_i (out_ready),
    .valid_o      (held_valid),
    .item_o       (held_item)
  );

  pcid_core #(
    .PIN_COUNT  (PIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (held_item),
    .result_o    (core_result)
  );

  pcid_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance),
    .result_i  (core_result),
    .ready_o   (out_ready),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .result_o  (out_result)
  );

  // struct packs fire_mask lowest, counter_value highest
  assign m_axis_tdata_o = out_result;

endmodule

>>> src/pcid_checker.sv
// port-level checks of the pin change interrupt dispatcher, bound to the top level
// depends on pcid_pkg and pin_change_irq_dispatch_top
`timescale 1ns / 1ps

module pcid_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_i,
  input logic                             m_axis_tready_i,
  input logic [pcid_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i
);

  logic [15:0] fire;
  logic [15:0] changed;
  logic [31:0] value;

  assign fire    = m_axis_tdata_i[15:0];
  assign changed = m_axis_tdata_i[31:16];
  assign value   = m_axis_tdata_i[63:32];

  // a pin can only fire if it changed
  a_fire_in_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> ((fire & ~changed) == 16'd0))
    else $error("fire_mask has a pin that did not change");

  // a counter read never carries change information
  a_read_no_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && (value != 32'd0)) |-> (changed == 16'd0))
    else $error("counter read with nonzero changed_mask");

  // nothing is presented right after reset
  a_idle_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_i)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=> (m_axis_tvalid_i && $stable(m_axis_tdata_i)))
    else $error("stalled result changed");

endmodule

bind pin_change_irq_dispatch_top pcid_checker u_pcid_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);

>>> bench/pcid_dispatch_checker.sv
// watches the config port and both streams of the pin change dispatcher, predicts each result
// and compares it with what the block returns; depends on pcid_pkg only
`timescale 1ns / 1ps

module pcid_dispatch_checker
  import pcid_pkg::*;
#(
  parameter int PIN_COUNT  = PIN_COUNT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  // pin_levels [15:0], counter_index [19:16], zero fill [23:20]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action [0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  // fire_mask [15:0], changed_mask [31:16], counter_value [63:32]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic [MAX_PINS-1:0] LIVE_PINS  = MAX_PINS'((32'd1 << PIN_COUNT) - 32'd1);
  localparam logic [VALUE_W-1:0]  COUNT_MASK = VALUE_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic [MAX_PINS-1:0]   en_mask;
  logic [2*MAX_PINS-1:0] trig_cfg;
  logic [MAX_PINS-1:0]   prev_levels;
  logic                  levels_primed;
  logic [VALUE_W-1:0]    pin_counts [MAX_PINS];
  result_t               pending_dispatch [$];

  // one step of the dispatcher on a copy of its state
  function automatic result_t derive_dispatch(input item_t it);
    result_t             r;
    logic [MAX_PINS-1:0] levels;
    logic [1:0]          mode;
    r = '0;
    levels = it.pin_levels & LIVE_PINS;
    if (it.action == ACT_READ) begin
      if (int'(it.counter_index) < PIN_COUNT) r.counter_value = pin_counts[it.counter_index];
    end else if (!levels_primed) begin
      prev_levels   = levels;
      levels_primed = 1'b1;
    end else begin
      r.changed_mask = prev_levels ^ levels;
      prev_levels    = levels;
      for (int i = 0; i < PIN_COUNT; i++) begin
        if (r.changed_mask[i]) begin
          pin_counts[i] = (pin_counts[i] + 1) & COUNT_MASK;
          mode = trig_cfg[2*i +: 2];
          if (en_mask[i] && !(mode == TRIG_RISE && !levels[i])
              && !(mode == TRIG_FALL && levels[i]))
            r.fire_mask[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_ni) begin
      en_mask       = '0;
      trig_cfg      = '0;
      prev_levels   = '0;
      levels_primed = 1'b0;
      for (int i = 0; i < MAX_PINS; i++) pin_counts[i] = '0;
      pending_dispatch.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IRQ_ENABLE: en_mask  = cfg_wdata_i[MAX_PINS-1:0];
          CFG_TRIG_MODE:  trig_cfg = cfg_wdata_i[2*MAX_PINS-1:0];
          default: ;
        endcase
      end
      // results first, so an item taken at this edge never pairs with an older result
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_i);
        if (pending_dispatch.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result fire %h changed %h count %h", $time,
                     got.fire_mask, got.changed_mask, got.counter_value);
        end else begin
          want = pending_dispatch.pop_front();
          if (got.fire_mask !== want.fire_mask || got.changed_mask !== want.changed_mask
              || got.counter_value !== want.counter_value) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch fire %h/%h changed %h/%h count %h/%h (exp/act)", $time,
                       want.fire_mask, got.fire_mask, want.changed_mask, got.changed_mask,
                       want.counter_value, got.counter_value);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        it.action        = action_e'(s_axis_tuser_i[0]);
        it.pin_levels    = s_axis_tdata_i[MAX_PINS-1:0];
        it.counter_index = s_axis_tdata_i[MAX_PINS +: IDX_W];
        pending_dispatch.push_back(derive_dispatch(it));
      end
      pending_o = pending_dispatch.size();
    end
  end

endmodule

>>> bench/testbench.sv
// stimulus and verdict for the pin change interrupt dispatcher
// depends on pcid_pkg, pin_change_irq_dispatch_top and pcid_dispatch_checker
`timescale 1ns / 1ps

module testbench;
  import pcid_pkg::*;

  localparam int PIN_COUNT    = PIN_COUNT_DEF;
  localparam int COUNT_BITS   = COUNT_BITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off in the last phase
  localparam int BLOCK_ITEMS  = 76;   // random items per configuration
  localparam int SETTLE       = 4;    // extra idle margin before the configuration writes

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // pin_levels [15:0], counter_index [19:16], zero fill [23:20]
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  // action [0]
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // fire_mask [15:0], changed_mask [31:16], counter_value [63:32]
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  int fail_count;
  int pending;
  int cycle_count;

  // idling odds in percent, set per phase by the stimulus process
  int send_idle_pct;
  int recv_idle_pct;
  logic stall_req;
  logic stall_served;

  // last sample sent, so random samples can flip only a few pins
  logic [MAX_PINS-1:0] last_sent_levels;

  pin_change_irq_dispatch_top #(
    .PIN_COUNT  (PIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  pcid_dispatch_checker #(
    .PIN_COUNT  (PIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off when asked
  initial begin
    m_axis_tready_i = 1'b0;
    stall_served    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req && !stall_served) begin
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        stall_served = 1'b1;
      end else begin
        m_axis_tready_i = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one item; returns with tvalid still high right after the accepting edge
  task automatic send_item(input action_e act, input logic [MAX_PINS-1:0] levels,
                           input logic [IDX_W-1:0] idx);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {4'b0000, idx, levels};
    s_axis_tuser_i  = act;
    if (act == ACT_SAMPLE) last_sent_levels = levels;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // registers may only change with nothing in flight
  task automatic reconfigure(input logic [MAX_PINS-1:0] en,
                             input logic [CFG_DATA_W-1:0] trig);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    write_cfg(CFG_IRQ_ENABLE, CFG_DATA_W'(en));
    write_cfg(CFG_TRIG_MODE, trig);
  endtask

  task automatic send_random_item();
    logic [MAX_PINS-1:0] levels;
    int pick;
    if ($urandom_range(0, 99) < 22) begin
      send_item(ACT_READ, MAX_PINS'($urandom), IDX_W'($urandom_range(0, 15)));
    end else begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: levels = '0;
        1: levels = '1;
        2, 3, 4, 5: begin
          // flip a few pins so single edges dominate
          levels = last_sent_levels;
          repeat ($urandom_range(1, 3)) levels[$urandom_range(0, MAX_PINS - 1)] ^= 1'b1;
        end
        default: levels = MAX_PINS'($urandom);
      endcase
      send_item(ACT_SAMPLE, levels, IDX_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    int blk;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_IRQ_ENABLE;
    cfg_wdata_i      = '0;
    s_axis_tvalid_i  = 1'b0;
    s_axis_tdata_i   = '0;
    s_axis_tuser_i   = ACT_SAMPLE;
    send_idle_pct    = 35;
    recv_idle_pct    = 79;
    stall_req        = 1'b0;
    cycle_count      = 0;
    last_sent_levels = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset config, so nothing is enabled yet
    send_item(ACT_READ, 16'hFFFF, 4'd0);     // read before the first sample
    send_item(ACT_SAMPLE, 16'hA5A5, 4'd15);  // primes the previous levels only
    send_item(ACT_SAMPLE, 16'h5A5A, 4'd0);   // all pins change, none enabled
    send_item(ACT_READ, 16'h0000, 4'd15);
    // any edge on every pin
    reconfigure(16'hFFFF, 32'h0000_0000);
    send_item(ACT_SAMPLE, 16'hFFFF, 4'd0);
    send_item(ACT_SAMPLE, 16'h0000, 4'd0);
    send_item(ACT_SAMPLE, 16'h0000, 4'd0);   // no change at all
    // rising only
    reconfigure(16'hFFFF, 32'h5555_5555);
    send_item(ACT_SAMPLE, 16'hFFFF, 4'd0);
    send_item(ACT_SAMPLE, 16'h0000, 4'd0);
    // falling only
    reconfigure(16'hFFFF, 32'hAAAA_AAAA);
    send_item(ACT_SAMPLE, 16'h00FF, 4'd0);
    send_item(ACT_SAMPLE, 16'h0000, 4'd0);
    // alternate any-edge code, only the end pins enabled
    reconfigure(16'h8001, 32'hFFFF_FFFF);
    send_item(ACT_SAMPLE, 16'hFFFF, 4'd0);
    send_item(ACT_SAMPLE, 16'h7FFE, 4'd0);
    // all four modes side by side
    reconfigure(16'hFFFF, 32'hE4E4_E4E4);
    send_item(ACT_SAMPLE, 16'h0000, 4'd0);
    send_item(ACT_SAMPLE, 16'hFFFF, 4'd0);
    send_item(ACT_READ, 16'h0000, 4'd0);
    send_item(ACT_READ, 16'h0000, 4'd15);
    send_item(ACT_READ, 16'h0000, 4'd7);

    // random: three idling phases, a few configurations in each
    blk = 0;
    for (int phase = 0; phase < 3; phase++) begin
      for (int sub = 0; sub < 3; sub++) begin
        case (blk % 4)
          0: reconfigure(16'hFFFF, 32'h0000_0000);
          1: reconfigure(MAX_PINS'($urandom), $urandom);
          2: reconfigure(16'h0000, 32'hFFFF_FFFF);
          default: reconfigure(MAX_PINS'($urandom), 32'hAAAA_AAAA ^ $urandom);
        endcase
        blk++;
        if (sub == 0) begin
          case (phase)
            0: begin send_idle_pct = 35; recv_idle_pct = 79; end
            1: begin send_idle_pct = 79; recv_idle_pct = 35; end
            default: begin
              // no idling; the receiver holds off once so the block backs up
              send_idle_pct = 0;
              recv_idle_pct = 0;
              stall_req     = 1'b1;
            end
          endcase
        end
        repeat (BLOCK_ITEMS) send_random_item();
      end
    end

    // drain, then let the pipeline go quiet
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
